@@ src/tba_pkg.sv @@
// Shared types and constants for the time-binned averager.
`timescale 1ns / 1ps

package tba_pkg;

   localparam int MAX_BINS_DEF = 256;

   localparam int OP_W      = 2;
   localparam int SLOT_W    = 9;
   localparam int STAMP_W   = 32;
   localparam int VAL_W     = 32;
   localparam int BINS_W    = 9;
   localparam int BINOUT_W  = 8;
   localparam int MEAN_W    = 32;
   localparam int CNT_W     = 16;
   localparam int SUM_W     = 48;
   localparam int DIV_STEPS = SUM_W;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 56;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // register word index, taken from the word-select bit of the address
   localparam logic CSR_BINS_IDX = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_END    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      RD_FIRST = 2'd0,
      RD_LAST  = 2'd1,
      RD_NEXT  = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic       latch;
      logic       mem_write;
      rd_sel_type rd_sel;
      logic       walk_init;
      logic       walk_step;
      logic       start_bin;
      logic       accumulate;
      logic       close_start;
      logic       clear_run;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            stamp_below;
      logic            more;
      logic            active;
      logic            same_bin;
      logic            div_busy;
      logic            out_free;
   } sts_type;

endpackage

@@ src/tba_divider.sv @@
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module tba_divider
   import tba_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  dividend,
   input  logic        [CNT_W-1:0]  divisor,
   output logic                     busy,
   output logic signed [MEAN_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIV_STEPS);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  den_ff, den_in;

   logic [CNT_W:0]    trial;
   logic [SUM_W-1:0]  mag;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? -dividend : dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = CNT_W'(trial);
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = STEP_W'(step_ff + 1'b1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      den_ff <= den_in;
   end

   assign mag      = neg_ff ? -quo_ff : quo_ff;
   assign quotient = MEAN_W'(mag);
   assign busy     = busy_ff;

endmodule

@@ src/tba_datapath.sv @@
// Datapath: edge memory, bin walk, running sum and count, divider and result register.
`timescale 1ns / 1ps

module tba_datapath
   import tba_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic [BINS_W-1:0]      bins_reg,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int BW    = $clog2(MAX_BINS + 1);
   localparam int DEPTH = MAX_BINS + 1;

   // latched transaction
   logic [OP_W-1:0]           op_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [STAMP_W-1:0]        stamp_ff;
   logic signed [VAL_W-1:0]   value_ff;

   logic [STAMP_W-1:0]        edge_mem [DEPTH];
   logic [STAMP_W-1:0]        rd_data_ff;
   logic [BW-1:0]             rd_addr;

   logic [BW-1:0]             bin_ff, bin_in;
   logic [BW-1:0]             open_bin_ff, open_bin_in;
   logic                      active_ff, active_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   logic [BW-1:0]             close_bin_ff;
   logic [CNT_W-1:0]          close_count_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [BINOUT_W-1:0]       rsp_bin_ff;
   logic signed [MEAN_W-1:0]  rsp_mean_ff;
   logic [CNT_W-1:0]          rsp_count_ff;

   logic [BW-1:0]             nbins;
   logic                      slot_ok;
   logic signed [SUM_W-1:0]   value_ext;
   logic                      div_busy;
   logic signed [MEAN_W-1:0]  div_quo;

   // clamp the bin count to 1..MAX_BINS
   always_comb begin
      if (bins_reg == '0) begin
         nbins = BW'(1);
      end else if (32'(bins_reg) > 32'(MAX_BINS)) begin
         nbins = BW'(MAX_BINS);
      end else begin
         nbins = BW'(bins_reg);
      end
   end

   assign slot_ok   = 32'(slot_ff) <= 32'(MAX_BINS);
   assign value_ext = SUM_W'(value_ff);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= req_tuser;
         slot_ff  <= req_tdata[SLOT_W-1:0];
         stamp_ff <= req_tdata[SLOT_W +: STAMP_W];
         value_ff <= req_tdata[SLOT_W+STAMP_W +: VAL_W];
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_LAST:  rd_addr = nbins;
         RD_NEXT:  rd_addr = BW'(bin_ff + 1'b1);
         default:  rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write && slot_ok) begin
         edge_mem[BW'(slot_ff)] <= stamp_ff;
      end
      rd_data_ff <= edge_mem[rd_addr];
   end

   always_comb begin
      bin_in      = bin_ff;
      open_bin_in = open_bin_ff;
      active_in   = active_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      if (cmd.walk_init) begin
         bin_in = active_ff ? open_bin_ff : '0;
      end else if (cmd.walk_step) begin
         bin_in = BW'(bin_ff + 1'b1);
      end
      if (cmd.clear_run) begin
         open_bin_in = '0;
         active_in   = 1'b0;
         sum_in      = '0;
         count_in    = '0;
      end else if (cmd.start_bin) begin
         open_bin_in = bin_ff;
         active_in   = 1'b1;
         sum_in      = value_ext;
         count_in    = CNT_W'(1);
      end else if (cmd.accumulate && count_ff != COUNT_MAX) begin
         sum_in   = sum_ff + value_ext;
         count_in = CNT_W'(count_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff      <= '0;
         open_bin_ff <= '0;
         active_ff   <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
      end else begin
         bin_ff      <= bin_in;
         open_bin_ff <= open_bin_in;
         active_ff   <= active_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
      end
   end

   // hold the closing bin while the divider runs
   always_ff @(posedge clock) begin
      if (cmd.close_start) begin
         close_bin_ff   <= open_bin_ff;
         close_count_ff <= count_ff;
      end
   end

   tba_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.close_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.out_load) begin
         rsp_bin_ff   <= BINOUT_W'(close_bin_ff);
         rsp_mean_ff  <= div_quo;
         rsp_count_ff <= close_count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_mean_ff, rsp_bin_ff};

   assign sts.op          = op_ff;
   assign sts.stamp_below = stamp_ff < rd_data_ff;
   assign sts.more        = ({1'b0, bin_ff} + 1'b1) < {1'b0, nbins};
   assign sts.active      = active_ff;
   assign sts.same_bin    = bin_ff == open_bin_ff;
   assign sts.div_busy    = div_busy;
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

endmodule

@@ src/tba_ctrl.sv @@
// Controller: sequences edge checks, the bin walk, accumulation and bin closing.
`timescale 1ns / 1ps

module tba_ctrl
   import tba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_DISPATCH  = 9'b000000010,
      ST_CHK_FIRST = 9'b000000100,
      ST_CHK_LAST  = 9'b000001000,
      ST_WALK_RD   = 9'b000010000,
      ST_WALK_CMP  = 9'b000100000,
      ST_DECIDE    = 9'b001000000,
      ST_DIV       = 9'b010000000,
      ST_DONE      = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_FIRST;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (op_type'(sts.op))
               OP_LOAD: begin
                  cmd.mem_write = 1'b1;
                  state_in      = ST_IDLE;
               end
               OP_SAMPLE: begin
                  cmd.rd_sel = RD_FIRST;
                  state_in   = ST_CHK_FIRST;
               end
               OP_END: begin
                  cmd.clear_run = 1'b1;
                  if (sts.active) begin
                     cmd.close_start = 1'b1;
                     state_in        = ST_DIV;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_CHK_FIRST: begin
            if (sts.stamp_below) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rd_sel = RD_LAST;
               state_in   = ST_CHK_LAST;
            end
         end
         ST_CHK_LAST: begin
            if (!sts.stamp_below) begin
               state_in = ST_IDLE;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            if (sts.more) begin
               cmd.rd_sel = RD_NEXT;
               state_in   = ST_WALK_CMP;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_WALK_CMP: begin
            // advance while the next edge is at or before the stamp
            if (!sts.stamp_below) begin
               cmd.walk_step = 1'b1;
               state_in      = ST_WALK_RD;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!sts.active) begin
               cmd.start_bin = 1'b1;
               state_in      = ST_IDLE;
            end else if (!sts.same_bin) begin
               cmd.close_start = 1'b1;
               cmd.start_bin   = 1'b1;
               state_in        = ST_DIV;
            end else begin
               cmd.accumulate = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;

endmodule

@@ src/time_binned_averager.sv @@
// Top level of the time-binned averager: configuration register, controller and datapath.
//
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/req_tready  tuser: op; tdata: edge_slot, stamp, sample_value
//  rsp_     out  rsp_tvalid/rsp_tready  tdata: bin_number, mean_value, sample_count
//  csr_     in   APB write/read         bins_in_use at byte address 0
//
//  An edge load, an unknown op or an end with no open bin returns to idle at dispatch; a
//  sample outside the edges is dropped at the first- or last-edge check, and one inside
//  walks the bins, stopping on an edge above the stamp or at the last bin, as the single
//  edge-memory read port is visited once per edge. Closing a bin adds 48 division steps,
//  a divider-done check and a result-register load. Reset is synchronous and clears all
//  control state; edges are not cleared. A waiting result holds the next close and intake.
`timescale 1ns / 1ps

module time_binned_averager
   import tba_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [8:0] edge_slot, [40:9] stamp, [72:41] sample_value, [79:73] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] op
   input  logic [OP_W-1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] bin_number, [39:8] mean_value, [55:40] sample_count
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [BINS_W-1:0] bins_ff, bins_in;
   logic              csr_wr;
   cmd_type           cmd;
   sts_type           sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      bins_in = bins_ff;
      if (csr_wr && csr_paddr[2] == CSR_BINS_IDX) begin
         bins_in = csr_pwdata[BINS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_ff <= BINS_W'(1);
      end else begin
         bins_ff <= bins_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_BINS_IDX) ? CSR_DATA_W'(bins_ff) : '0;

   tba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tba_datapath #(
      .MAX_BINS (MAX_BINS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .bins_reg   (bins_ff),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a reported bin always holds at least one sample
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:40] != '0)
      else $error("result with zero sample count");

   // the divider is idle whenever a new transaction may enter
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.div_busy)
      else $error("divider busy while taking input");

   // only an open bin is closed
   a_close_active: assert property (@(posedge clock) disable iff (reset)
      cmd.close_start |-> sts.active)
      else $error("close issued with no open bin");

   // a result is loaded only once the divider has finished
   a_load_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !sts.div_busy && sts.out_free)
      else $error("result loaded while divider busy or register full");

endmodule
